/* hw/rtl/md5_pkg.sv */
// ----------------------------------------------------------------------------
// md5_pkg: shared types and constants for the MD5 digest block
// Round constants, shift amounts, message index schedule and initial vector.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] PAD_WORD = 32'h00000080;

  // Queue entry from front end to compression engine
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;   // word completes a block
    logic        msg_end;   // block is the final one of the message
  } md5_ent_t;

  typedef enum logic [1:0] {
    FE_TAKE,
    FE_ZERO,
    FE_LEN_LO,
    FE_LEN_HI
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_FILL,
    BE_ROUND,
    BE_ADD,
    BE_OUT
  } be_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index per round
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/md5_ram.sv */
// ----------------------------------------------------------------------------
// md5_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module md5_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/md5_front.sv */
// ----------------------------------------------------------------------------
// md5_front: input classifier and padder
// Takes message words, counts length, and emits padded block words.
// ----------------------------------------------------------------------------
module md5_front import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] message_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        q_valid,
  output md5_ent_t    q_ent,
  input  logic        q_stall
);

  fe_state_t   state, state_next;
  logic [63:0] bit_length;
  logic [3:0]  word_fill;
  logic        pad_pend;   // full last word: pad word still to send

  logic [2:0]  nb;
  logic [31:0] mask, tail;
  logic        push;
  logic [3:0]  fill_inc;

  // byte count clamp and tail word for short last word
  always_comb begin
    nb = (!last_word || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    case (nb)
      3'd0: mask = 32'h00000000;
      3'd1: mask = 32'h000000ff;
      3'd2: mask = 32'h0000ffff;
      3'd3: mask = 32'h00ffffff;
      default: mask = 32'hffffffff;
    endcase
    tail = (message_word & mask) | (PAD_WORD << {nb[1:0], 3'b000});
  end

  assign push     = q_valid && !q_stall;
  assign fill_inc = word_fill + 4'd1;

  // queue entry and next state
  always_comb begin
    state_next = state;
    q_valid    = 1'b0;
    q_ent      = '0;
    in_stall   = 1'b1;
    case (state)
      FE_TAKE: begin
        if (pad_pend) begin
          q_valid = 1'b1;
          q_ent.word = PAD_WORD;
        end else begin
          in_stall = q_stall;
          q_valid  = in_valid;
          q_ent.word = (last_word && nb != 3'd4) ? tail : message_word;
        end
        q_ent.blk_end = (word_fill == 4'd15);
      end
      FE_ZERO: begin
        q_valid = 1'b1;
        q_ent.blk_end = (word_fill == 4'd15);
      end
      FE_LEN_LO: begin
        q_valid = 1'b1;
        q_ent.word = bit_length[31:0];
      end
      FE_LEN_HI: begin
        q_valid = 1'b1;
        q_ent.word = bit_length[63:32];
        q_ent.blk_end = 1'b1;
        q_ent.msg_end = 1'b1;
      end
      default: ;
    endcase
    if (push) begin
      case (state)
        FE_TAKE: begin
          if (pad_pend || (last_word && nb != 3'd4)) begin
            state_next = (fill_inc == 4'd14) ? FE_LEN_LO : FE_ZERO;
          end
        end
        FE_ZERO: begin
          if (fill_inc == 4'd14) state_next = FE_LEN_LO;
        end
        FE_LEN_LO: state_next = FE_LEN_HI;
        FE_LEN_HI: state_next = FE_TAKE;
        default: state_next = FE_TAKE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FE_TAKE;
      bit_length <= '0;
      word_fill  <= '0;
      pad_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        word_fill <= (state == FE_LEN_HI) ? 4'd0 : fill_inc;
        if (state == FE_LEN_HI) bit_length <= '0;
        if (state == FE_TAKE && pad_pend) pad_pend <= 1'b0;
        if (state == FE_TAKE && !pad_pend) begin
          bit_length <= bit_length + {58'd0, nb, 3'b000};
          if (last_word && nb == 3'd4) pad_pend <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/md5_queue.sv */
// ----------------------------------------------------------------------------
// md5_queue: two-entry queue between front end and compression engine
// Lets either side stall on its own.
// ----------------------------------------------------------------------------
module md5_queue import md5_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  input  md5_ent_t wr_ent,
  output logic     wr_stall,
  output logic     rd_valid,
  output md5_ent_t rd_ent,
  input  logic     rd_stall
);

  md5_ent_t   slot [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       wr, rd;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_ent   = slot[rptr];
  assign wr       = wr_valid && !wr_stall;
  assign rd       = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (wr) slot[wptr] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* hw/rtl/md5_core.sv */
// ----------------------------------------------------------------------------
// md5_core: compression engine
// Buffers 16 words, runs 64 rounds one per cycle, emits the digest.
// ----------------------------------------------------------------------------
module md5_core import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  md5_ent_t    q_ent,
  output logic        q_stall,
  output logic [31:0] digest_word,
  output logic        digest_last,
  output logic        out_valid,
  input  logic        out_stall
);

  be_state_t   state, state_next;
  logic [3:0]  fill;
  logic [5:0]  rnd;
  logic        msg_end;
  logic [31:0] ra, rb, rc, rd;
  logic [31:0] ca, cb, cc, cd;
  logic [1:0]  oidx;
  logic [31:0] mdata;
  logic [5:0]  rd_rnd;
  logic        take;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;

  assign take    = (state == BE_FILL) && q_valid;
  assign q_stall = (state != BE_FILL);

  // read address leads the round counter by one (registered read)
  assign rd_rnd = (state == BE_FILL) ? 6'd0 : 6'(rnd + 6'd1);

  md5_ram #(.Width(32), .Depth(16)) u_buf (
    .clk   (clk),
    .we    (take),
    .waddr (fill),
    .wdata (q_ent.word),
    .raddr (round_g(rd_rnd)),
    .rdata (mdata)
  );

  // one MD5 round
  always_comb begin
    case (rnd[5:4])
      2'd0: f = (rb & rc) | (~rb & rd);
      2'd1: f = (rd & rb) | (~rd & rc);
      2'd2: f = rb ^ rc ^ rd;
      default: f = rc ^ (rb | ~rd);
    endcase
    sum = f + ra + round_k(rnd) + mdata;
    sh  = round_s(rnd);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_next = state;
    case (state)
      BE_FILL:  if (take && q_ent.blk_end) state_next = BE_ROUND;
      BE_ROUND: if (rnd == 6'd63) state_next = BE_ADD;
      BE_ADD:   state_next = msg_end ? BE_OUT : BE_FILL;
      BE_OUT:   if (!out_stall && oidx == 2'd3) state_next = BE_FILL;
      default:  state_next = BE_FILL;
    endcase
  end

  assign out_valid   = (state == BE_OUT);
  assign digest_last = (oidx == 2'd3);
  always_comb begin
    case (oidx)
      2'd0: digest_word = ca;
      2'd1: digest_word = cb;
      2'd2: digest_word = cc;
      default: digest_word = cd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BE_FILL;
      fill  <= '0;
      rnd   <= '0;
      oidx  <= '0;
      msg_end <= 1'b0;
      ca <= IV_A; cb <= IV_B; cc <= IV_C; cd <= IV_D;
      ra <= '0; rb <= '0; rc <= '0; rd <= '0;
    end else begin
      state <= state_next;
      case (state)
        BE_FILL: begin
          if (take) begin
            fill <= fill + 4'd1;
            if (q_ent.blk_end) begin
              msg_end <= q_ent.msg_end;
              rnd <= '0;
              ra <= ca; rb <= cb; rc <= cc; rd <= cd;
            end
          end
        end
        BE_ROUND: begin
          ra <= rd;
          rd <= rc;
          rc <= rb;
          rb <= rb + rot;
          rnd <= rnd + 6'd1;
        end
        BE_ADD: begin
          ca <= ca + ra; cb <= cb + rb; cc <= cc + rc; cd <= cd + rd;
          fill <= '0;
          oidx <= '0;
        end
        BE_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 2'd1;
            if (oidx == 2'd3) begin
              ca <= IV_A; cb <= IV_B; cc <= IV_C; cd <= IV_D;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/md5_message_digest.sv */
// ----------------------------------------------------------------------------
// md5_message_digest: streaming MD5 hash engine
// Pads the message, compresses 16-word blocks, emits four digest words.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake           | payload
//   input    | in        | in_valid / in_stall | message_word, valid_bytes, last_word
//   output   | out       | out_valid/out_stall | digest_word, digest_last
//
// A block of 16 words is written into the buffer, run through 64 rounds on
// the single round unit and added in; the core takes no words until it is done.
// The last word adds padding words and one or two blocks, then four outputs.
// Synchronous reset loads the initial vector; the buffer needs no clearing.
// Stalls on the output hold the engine; a two-entry queue decouples the front.
module md5_message_digest import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] message_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        digest_last
);

  logic     f_valid, f_stall, c_valid, c_stall;
  md5_ent_t f_ent, c_ent;

  md5_front u_front (
    .clk, .rst, .message_word, .valid_bytes, .last_word, .in_valid, .in_stall,
    .q_valid (f_valid), .q_ent (f_ent), .q_stall (f_stall)
  );

  md5_queue u_queue (
    .clk, .rst,
    .wr_valid (f_valid), .wr_ent (f_ent), .wr_stall (f_stall),
    .rd_valid (c_valid), .rd_ent (c_ent), .rd_stall (c_stall)
  );

  md5_core u_core (
    .clk, .rst, .q_valid (c_valid), .q_ent (c_ent), .q_stall (c_stall),
    .digest_word, .digest_last, .out_valid, .out_stall
  );

endmodule
